// File: rtl/pvr_pkg.sv
// ----------------------------------------------------------------------------
// pvr_pkg
// Shared widths, constants, register indexes and CORDIC tables for the
// polar vector resultant block.
// ----------------------------------------------------------------------------
package pvr_pkg;

    localparam int MAG_BITS        = 16;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int GUARD_BITS      = 16;
    localparam int AZ_W            = 15;
    localparam int SUM_MAG_W       = MAG_BITS + 1;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;

    // component datapath width (signed) and rotation angle width (signed)
    localparam int COMP_W = 38;
    localparam int ZR_W   = 34;

    localparam logic [AZ_W-1:0] TURN_UNITS    = AZ_W'(360 << ANGLE_FRAC_BITS);
    localparam logic [AZ_W-1:0] QUARTER_UNITS = AZ_W'(90 << ANGLE_FRAC_BITS);
    localparam logic [31:0]     HALF_BIN      = 32'h8000_0000;
    localparam logic [31:0]     QUARTER_BIN   = 32'h4000_0000;
    localparam logic [31:0]     GAIN_K        = 32'd2608131496;
    localparam logic [SUM_MAG_W-1:0] MAG_SUM_MAX =
        SUM_MAG_W'((2 ** (MAG_BITS + 1)) - 2);

    // units to binary turns: t = u*2^23/45 rounded, split as
    // u*floor(2^23/45) + floor((23u + 22)/45); the second part uses a
    // reciprocal multiply that is exact for 20-bit operands.
    localparam logic [17:0] TURN_MUL   = 18'd186413;
    localparam logic [4:0]  TURN_REM   = 5'd23;
    localparam logic [4:0]  TURN_BIAS  = 5'd22;
    localparam logic [20:0] RECIP_45   = 21'd1491309;
    localparam int          RECIP_SHIFT = 26;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODATA_VALUE  = 2'd1;

    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// File: rtl/pvr_in_if.sv
// ----------------------------------------------------------------------------
// pvr_in_if
// Pixel input channel: two polar vectors per beat.
// ----------------------------------------------------------------------------
interface pvr_in_if;
    logic                            valid;
    logic                            ready;
    logic [pvr_pkg::MAG_BITS-1:0]    magnitude_a;
    logic [pvr_pkg::AZ_W-1:0]        azimuth_a;
    logic [pvr_pkg::MAG_BITS-1:0]    magnitude_b;
    logic [pvr_pkg::AZ_W-1:0]        azimuth_b;

    modport source (output valid, magnitude_a, azimuth_a, magnitude_b, azimuth_b,
                    input ready);
    modport sink   (input valid, magnitude_a, azimuth_a, magnitude_b, azimuth_b,
                    output ready);
endinterface

// File: rtl/pvr_out_if.sv
// ----------------------------------------------------------------------------
// pvr_out_if
// Result channel: resultant magnitude, azimuth and no-data flag per beat.
// ----------------------------------------------------------------------------
interface pvr_out_if;
    logic                            valid;
    logic                            ready;
    logic [pvr_pkg::SUM_MAG_W-1:0]   sum_magnitude;
    logic [pvr_pkg::AZ_W-1:0]        sum_azimuth;
    logic                            missing_pixel;

    modport source (output valid, sum_magnitude, sum_azimuth, missing_pixel,
                    input ready);
    modport sink   (input valid, sum_magnitude, sum_azimuth, missing_pixel,
                    output ready);
endinterface

// File: rtl/polar_vector_resultant.sv
// ----------------------------------------------------------------------------
// polar_vector_resultant
// Adds two compass-azimuth polar vectors per pixel and returns the rounded
// resultant magnitude and azimuth, with optional no-data masking.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                             | beat
//  i_pix     | in  | magnitude_a, azimuth_a, magnitude_b, azimuth_b      | one pixel
//  o_res     | out | sum_magnitude, sum_azimuth, missing_pixel           | one result
//  i_cfg_*   | in  | i_cfg_idx, i_cfg_wdata under i_cfg_we               | one register
//
//  The pipeline holds three front-end stages, the rotation CORDIC, the
//  component add, the vectoring CORDIC, a multiply stage and the output
//  register. One pixel is taken per cycle while o_res is not stalled.
//  Synchronous active-low reset clears the valid bits and the config registers.
//  A stall on o_res freezes the whole pipeline in place; i_pix.ready drops
//  only while the output register holds a beat that is not taken.
// ----------------------------------------------------------------------------
module polar_vector_resultant #(
    parameter int CORDIC_STAGES = 18
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pvr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pvr_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    pvr_in_if.sink                            i_pix,
    pvr_out_if.source                         o_res
);
    localparam int LAT = 2 * CORDIC_STAGES + 6;
    localparam int CW  = pvr_pkg::COMP_W;

    logic                              r_nd_en;
    logic [pvr_pkg::CFG_DATA_W-1:0]    r_nd_val;
    logic                              en;
    logic                              miss_in;
    logic                              r_vld  [LAT];
    logic                              r_miss [LAT];

    logic signed [CW-1:0]              fa_x, fb_x;
    logic signed [pvr_pkg::ZR_W-1:0]   fa_z, fb_z;
    logic signed [CW-1:0]              ra_x, ra_y, rb_x, rb_y;
    logic signed [CW-1:0]              sum_x, sum_y;
    logic signed [CW-1:0]              r_ax, r_ay;
    logic [31:0]                       r_az0;
    logic                              r_zero;
    logic signed [CW-1:0]              v_x;
    logic [31:0]                       v_z;
    logic                              v_zero;

    logic [CW-2:0]                     x_clamp;
    logic [63:0]                       lo_prod;
    logic [31:0]                       az_turn;
    logic [36:0]                       r_p_hi;
    logic [31:0]                       r_p_lo;
    logic [46:0]                       r_p_az;
    logic                              r_zero2;

    logic [37:0]                       gain_sum;
    logic [22:0]                       mag_rnd;
    logic [47:0]                       az_rnd;
    logic [pvr_pkg::AZ_W-1:0]          az_units;
    logic [pvr_pkg::SUM_MAG_W-1:0]     r_o_mag;
    logic [pvr_pkg::AZ_W-1:0]          r_o_az;
    logic                              r_o_miss;

    // advance everything whenever the output register is free or drained
    assign en          = !r_vld[LAT-1] || o_res.ready;
    assign i_pix.ready = en;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd_en  <= 1'b0;
            r_nd_val <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pvr_pkg::CFG_NODATA_ENABLE: r_nd_en  <= i_cfg_wdata[0];
                pvr_pkg::CFG_NODATA_VALUE:  r_nd_val <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // raw no-data compare on all four fields
    assign miss_in = r_nd_en &&
        (i_pix.magnitude_a == r_nd_val || {1'b0, i_pix.azimuth_a} == r_nd_val ||
         i_pix.magnitude_b == r_nd_val || {1'b0, i_pix.azimuth_b} == r_nd_val);

    // valid and no-data flag travel beside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_pix.valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_miss[0] <= miss_in;
            for (int k = 1; k < LAT; k++) begin
                r_miss[k] <= r_miss[k-1];
            end
        end
    end

    // polar to components, one front end and rotator per vector
    pvr_front u_front_a (
        .i_clk (i_clk), .i_en (en),
        .i_mag (i_pix.magnitude_a), .i_az (i_pix.azimuth_a),
        .o_x   (fa_x), .o_z (fa_z)
    );
    pvr_front u_front_b (
        .i_clk (i_clk), .i_en (en),
        .i_mag (i_pix.magnitude_b), .i_az (i_pix.azimuth_b),
        .o_x   (fb_x), .o_z (fb_z)
    );
    pvr_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_a (
        .i_clk (i_clk), .i_en (en), .i_x (fa_x), .i_z (fa_z),
        .o_x   (ra_x), .o_y (ra_y)
    );
    pvr_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_b (
        .i_clk (i_clk), .i_en (en), .i_x (fb_x), .i_z (fb_z),
        .o_x   (rb_x), .o_y (rb_y)
    );

    // add components, flag a null resultant, fold x into the right half-plane
    assign sum_x = ra_x + rb_x;
    assign sum_y = ra_y + rb_y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero <= (sum_x == '0) && (sum_y == '0);
            if (sum_x < 0) begin
                r_ax  <= -sum_x;
                r_ay  <= -sum_y;
                r_az0 <= pvr_pkg::HALF_BIN;
            end else begin
                r_ax  <= sum_x;
                r_ay  <= sum_y;
                r_az0 <= '0;
            end
        end
    end

    pvr_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec (
        .i_clk  (i_clk), .i_en (en),
        .i_x    (r_ax), .i_y (r_ay), .i_z (r_az0), .i_zero (r_zero),
        .o_x    (v_x), .o_z (v_z), .o_zero (v_zero)
    );

    // gain correction and angle scale-back products
    assign x_clamp = (v_x < 0) ? '0 : v_x[CW-2:0];
    assign lo_prod = 64'(x_clamp[31:0]) * 64'(pvr_pkg::GAIN_K);
    assign az_turn = pvr_pkg::QUARTER_BIN - v_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_hi  <= 37'(x_clamp[CW-2:32]) * 37'(pvr_pkg::GAIN_K);
            r_p_lo  <= lo_prod[63:32];
            r_p_az  <= 47'(az_turn) * 47'(pvr_pkg::TURN_UNITS);
            r_zero2 <= v_zero;
        end
    end

    // round, saturate, wrap, then select the special cases
    assign gain_sum = 38'(r_p_hi) + 38'(r_p_lo);
    assign mag_rnd  = 23'((39'(gain_sum) + (39'd1 << (pvr_pkg::GUARD_BITS - 1)))
                          >> pvr_pkg::GUARD_BITS);
    assign az_rnd   = 48'(r_p_az) + 48'h0000_8000_0000;
    assign az_units = az_rnd[32 +: pvr_pkg::AZ_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_miss[LAT-2]) begin
                r_o_mag  <= '0;
                r_o_az   <= '0;
                r_o_miss <= 1'b1;
            end else if (r_zero2) begin
                r_o_mag  <= '0;
                r_o_az   <= pvr_pkg::QUARTER_UNITS;
                r_o_miss <= 1'b0;
            end else begin
                r_o_mag  <= (mag_rnd > 23'(pvr_pkg::MAG_SUM_MAX))
                          ? pvr_pkg::MAG_SUM_MAX : mag_rnd[pvr_pkg::SUM_MAG_W-1:0];
                r_o_az   <= (az_units >= pvr_pkg::TURN_UNITS) ? '0 : az_units;
                r_o_miss <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_vld[LAT-1];
    assign o_res.sum_magnitude = r_o_mag;
    assign o_res.sum_azimuth   = r_o_az;
    assign o_res.missing_pixel = r_o_miss;

`ifndef SYNTH
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.missing_pixel |->
            o_res.sum_magnitude == '0 && o_res.sum_azimuth == '0)
        else $error("no-data result carries nonzero payload");

    a_az_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.sum_azimuth < pvr_pkg::TURN_UNITS)
        else $error("azimuth outside one turn");

    a_mag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.sum_magnitude <= pvr_pkg::MAG_SUM_MAX)
        else $error("magnitude above saturation limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |=> o_res.valid && $stable(o_res.sum_azimuth))
        else $error("pipeline moved under output stall");
`endif
endmodule

// File: rtl/pvr_front.sv
// ----------------------------------------------------------------------------
// pvr_front
// Three-stage front end: compass azimuth to math angle in binary turns,
// gain pre-scale of the magnitude, and half-plane fold for the rotator.
// ----------------------------------------------------------------------------
module pvr_front (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [pvr_pkg::MAG_BITS-1:0]         i_mag,
    input  logic [pvr_pkg::AZ_W-1:0]             i_az,
    output logic signed [pvr_pkg::COMP_W-1:0]    o_x,
    output logic signed [pvr_pkg::ZR_W-1:0]      o_z
);
    localparam int AW = pvr_pkg::AZ_W;

    logic [AW-1:0]                   az_red;
    logic [AW:0]                     math_raw;
    logic [AW-1:0]                   math_u;
    logic [AW-1:0]                   r_u;
    logic [pvr_pkg::MAG_BITS-1:0]    r_m;
    logic [19:0]                     rem_num;
    logic [40:0]                     rem_prod;
    logic [32:0]                     r_p1;
    logic [14:0]                     r_q;
    logic [31:0]                     r_gx;
    logic [31:0]                     t_sum;
    logic [31:0]                     t_fold;
    logic                            flip;
    logic [47:0]                     gain_prod;
    logic signed [pvr_pkg::COMP_W-1:0] r_x;
    logic signed [pvr_pkg::ZR_W-1:0]   r_z;

    // stage 1: reduce the azimuth into one turn, then to math angle
    always_comb begin
        az_red   = (i_az >= pvr_pkg::TURN_UNITS) ? i_az - pvr_pkg::TURN_UNITS : i_az;
        math_raw = {1'b0, pvr_pkg::QUARTER_UNITS} + {1'b0, pvr_pkg::TURN_UNITS}
                 - {1'b0, az_red};
        math_u   = (math_raw >= {1'b0, pvr_pkg::TURN_UNITS})
                 ? AW'(math_raw - {1'b0, pvr_pkg::TURN_UNITS}) : AW'(math_raw);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= math_u;
            r_m <= i_mag;
        end
    end

    // stage 2: split multiplies for the turn conversion, gain scale
    always_comb begin
        rem_num   = 20'(r_u) * 20'(pvr_pkg::TURN_REM) + 20'(pvr_pkg::TURN_BIAS);
        rem_prod  = 41'(rem_num) * 41'(pvr_pkg::RECIP_45);
        gain_prod = 48'(r_m) * 48'(pvr_pkg::GAIN_K);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= 33'(r_u) * 33'(pvr_pkg::TURN_MUL);
            r_q  <= rem_prod[pvr_pkg::RECIP_SHIFT +: 15];
            r_gx <= gain_prod[47:16];
        end
    end

    // stage 3: fold the left half-plane onto the right one
    always_comb begin
        t_sum  = r_p1[31:0] + 32'(r_q);
        flip   = (t_sum + pvr_pkg::QUARTER_BIN) >= pvr_pkg::HALF_BIN;
        t_fold = flip ? t_sum - pvr_pkg::HALF_BIN : t_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= flip ? -$signed({6'd0, r_gx}) : $signed({6'd0, r_gx});
            r_z <= $signed({{(pvr_pkg::ZR_W-32){t_fold[31]}}, t_fold});
        end
    end

    assign o_x = r_x;
    assign o_z = r_z;
endmodule

// File: rtl/pvr_cordic_rot.sv
// ----------------------------------------------------------------------------
// pvr_cordic_rot
// Rotation-mode CORDIC, one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module pvr_cordic_rot #(
    parameter int STAGES = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [pvr_pkg::COMP_W-1:0]    i_x,
    input  logic signed [pvr_pkg::ZR_W-1:0]      i_z,
    output logic signed [pvr_pkg::COMP_W-1:0]    o_x,
    output logic signed [pvr_pkg::COMP_W-1:0]    o_y
);
    logic signed [pvr_pkg::COMP_W-1:0] r_x [STAGES+1];
    logic signed [pvr_pkg::COMP_W-1:0] r_y [STAGES+1];
    logic signed [pvr_pkg::ZR_W-1:0]   r_z [STAGES+1];

    assign r_x[0] = i_x;
    assign r_y[0] = '0;
    assign r_z[0] = i_z;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [pvr_pkg::ZR_W-1:0] ANG =
            $signed({2'b00, pvr_pkg::ATAN_TURNS[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ANG;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ANG;
                end
            end
        end
    end

    assign o_x = r_x[STAGES];
    assign o_y = r_y[STAGES];
endmodule

// File: rtl/pvr_cordic_vec.sv
// ----------------------------------------------------------------------------
// pvr_cordic_vec
// Vectoring-mode CORDIC, one registered micro-rotation per stage; the angle
// accumulates modulo one turn. A zero flag rides along.
// ----------------------------------------------------------------------------
module pvr_cordic_vec #(
    parameter int STAGES = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [pvr_pkg::COMP_W-1:0]    i_x,
    input  logic signed [pvr_pkg::COMP_W-1:0]    i_y,
    input  logic [31:0]                          i_z,
    input  logic                                 i_zero,
    output logic signed [pvr_pkg::COMP_W-1:0]    o_x,
    output logic [31:0]                          o_z,
    output logic                                 o_zero
);
    logic signed [pvr_pkg::COMP_W-1:0] r_x [STAGES+1];
    logic signed [pvr_pkg::COMP_W-1:0] r_y [STAGES+1];
    logic [31:0]                       r_z [STAGES+1];
    logic                              r_zf [STAGES+1];

    assign r_x[0]  = i_x;
    assign r_y[0]  = i_y;
    assign r_z[0]  = i_z;
    assign r_zf[0] = i_zero;

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zf[i+1] <= r_zf[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + pvr_pkg::ATAN_TURNS[i];
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - pvr_pkg::ATAN_TURNS[i];
                end
            end
        end
    end

    assign o_x    = r_x[STAGES];
    assign o_z    = r_z[STAGES];
    assign o_zero = r_zf[STAGES];
endmodule

// File: bench/tb_polar_vector_resultant.sv
// ----------------------------------------------------------------------------
// tb_polar_vector_resultant
// Self-checking bench for the polar vector resultant block. A clocked driver
// feeds pixel beats from a queue in random bursts. A clocked monitor predicts
// each resultant with a bit-exact CORDIC model and checks every result beat
// in order. The receiver stalls on its own pattern, with one long hold-off.
// ----------------------------------------------------------------------------
module tb_polar_vector_resultant;

    localparam int  STAGES    = 18;
    localparam int  LATENCY   = 2 * STAGES + 6;
    localparam int  HALF_CLK  = 6;
    localparam int  AZ_TURN   = 360 << pvr_pkg::ANGLE_FRAC_BITS;
    localparam int  AZ_MAX_IN = (1 << pvr_pkg::AZ_W) - 1;
    localparam int  HOLD_AT   = 400;
    localparam int  HOLD_LEN  = 300;

    // register indexes past the end of the list; writes to them are dropped
    localparam logic [pvr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
    localparam logic [pvr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

    typedef struct packed {
        logic [pvr_pkg::MAG_BITS-1:0] mag_a;
        logic [pvr_pkg::AZ_W-1:0]     az_a;
        logic [pvr_pkg::MAG_BITS-1:0] mag_b;
        logic [pvr_pkg::AZ_W-1:0]     az_b;
    } t_pixel;

    typedef struct packed {
        logic [pvr_pkg::SUM_MAG_W-1:0] mag;
        logic [pvr_pkg::AZ_W-1:0]      az;
        logic                          missing;
    } t_resultant;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [pvr_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [pvr_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    pvr_in_if  pix ();
    pvr_out_if res ();

    polar_vector_resultant #(.CORDIC_STAGES(STAGES)) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix),
        .o_res       (res)
    );

    // bench copy of the configuration registers
    logic                           nodata_on;
    logic [pvr_pkg::CFG_DATA_W-1:0] nodata_code;

    t_pixel     pixels_pending [$];
    t_resultant resultants_due [$];

    int  errors;
    int  pixels_taken;
    int  results_seen;
    int  missing_seen;
    int  zero_seen;
    bit  pix_taken;

    // sender burst state
    int  burst_left;
    int  gap_left;

    // receiver pattern state
    int  rx_cycle;
    int  hold_left;
    bit  hold_done;

    always begin
        #HALF_CLK i_clk = 1'b1;
        #HALF_CLK i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bit-exact prediction
    // ------------------------------------------------------------------

    // floor(v * K), K the reciprocal of the CORDIC gain in Q32
    function automatic logic [63:0] gain_scale(input logic [63:0] v);
        logic [63:0] k;
        k = 64'(pvr_pkg::GAIN_K);
        return (v >> 32) * k + (((v & 64'hFFFF_FFFF) * k) >> 32);
    endfunction

    // Rotate one compass vector onto x (east) / y (north) with guard bits.
    function automatic void compass_to_xy(input logic [pvr_pkg::MAG_BITS-1:0] m,
                                          input logic [pvr_pkg::AZ_W-1:0] az,
                                          output longint x, output longint y);
        logic [63:0] math_u;
        logic [31:0] t;
        longint      z, dx, dy;
        math_u = (64'(pvr_pkg::QUARTER_UNITS) + 64'(AZ_TURN) - (64'(az) % 64'(AZ_TURN)))
                 % 64'(AZ_TURN);
        t = 32'(((math_u << 32) + 64'(AZ_TURN / 2)) / 64'(AZ_TURN));
        x = longint'(gain_scale(64'(m) << pvr_pkg::GUARD_BITS));
        y = 0;
        // fold the left half plane into the CORDIC's range
        if (32'(t + pvr_pkg::QUARTER_BIN) >= pvr_pkg::HALF_BIN) begin
            x = -x;
            t = t - pvr_pkg::HALF_BIN;
        end
        z = longint'($signed(t));
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy;
                z = z - longint'({32'h0, pvr_pkg::ATAN_TURNS[i]});
            end else begin
                x = x + dx; y = y - dy;
                z = z + longint'({32'h0, pvr_pkg::ATAN_TURNS[i]});
            end
        end
    endfunction

    function automatic t_resultant resolve_pixel(input t_pixel p);
        t_resultant  r;
        longint      xa, ya, xb, yb, x, y, dx, dy;
        logic [31:0] zv, az_t;
        logic [63:0] mag, az;
        r = '0;
        if (nodata_on && (p.mag_a == nodata_code || 16'(p.az_a) == nodata_code ||
                          p.mag_b == nodata_code || 16'(p.az_b) == nodata_code)) begin
            r.missing = 1'b1;
            return r;
        end
        compass_to_xy(p.mag_a, p.az_a, xa, ya);
        compass_to_xy(p.mag_b, p.az_b, xb, yb);
        x = xa + xb;
        y = ya + yb;
        // a null resultant points east, as atan2(0,0) does
        if (x == 0 && y == 0) begin
            r.az = pvr_pkg::QUARTER_UNITS;
            return r;
        end
        zv = '0;
        if (x < 0) begin
            x = -x; y = -y; zv = pvr_pkg::HALF_BIN;
        end
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; zv = zv + pvr_pkg::ATAN_TURNS[i];
            end else begin
                x = x - dx; y = y + dy; zv = zv - pvr_pkg::ATAN_TURNS[i];
            end
        end
        if (x < 0) x = 0;
        mag = (gain_scale(64'(x)) + (64'd1 << (pvr_pkg::GUARD_BITS - 1)))
              >> pvr_pkg::GUARD_BITS;
        if (mag > 64'(pvr_pkg::MAG_SUM_MAX)) mag = 64'(pvr_pkg::MAG_SUM_MAX);
        // back from math angle to compass, wrap a rounded full turn to zero
        az_t = pvr_pkg::QUARTER_BIN - zv;
        az = (64'(az_t) * 64'(AZ_TURN) + 64'h8000_0000) >> 32;
        if (az >= 64'(AZ_TURN)) az = 0;
        r.mag = pvr_pkg::SUM_MAG_W'(mag);
        r.az  = pvr_pkg::AZ_W'(az);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_pixel make_pixel(input int ma, input int aa,
                                          input int mb, input int ab);
        t_pixel p;
        p.mag_a = pvr_pkg::MAG_BITS'(ma);
        p.az_a  = pvr_pkg::AZ_W'(aa);
        p.mag_b = pvr_pkg::MAG_BITS'(mb);
        p.az_b  = pvr_pkg::AZ_W'(ab);
        return p;
    endfunction

    // Random pixel: mostly full range, some tiny magnitudes, some azimuths
    // past one turn; optionally plant the no-data code in one field.
    function automatic t_pixel random_pixel(input int plant_pct);
        t_pixel p;
        int     sel;
        p.mag_a = ($urandom_range(0, 4) == 0)
                ? pvr_pkg::MAG_BITS'($urandom_range(0, 15)) : pvr_pkg::MAG_BITS'($urandom);
        p.mag_b = ($urandom_range(0, 4) == 0)
                ? pvr_pkg::MAG_BITS'($urandom_range(0, 15)) : pvr_pkg::MAG_BITS'($urandom);
        p.az_a  = ($urandom_range(0, 9) == 0)
                ? pvr_pkg::AZ_W'($urandom_range(AZ_TURN, AZ_MAX_IN))
                : pvr_pkg::AZ_W'($urandom_range(0, AZ_TURN - 1));
        p.az_b  = ($urandom_range(0, 9) == 0)
                ? pvr_pkg::AZ_W'($urandom_range(AZ_TURN, AZ_MAX_IN))
                : pvr_pkg::AZ_W'($urandom_range(0, AZ_TURN - 1));
        // now and then make b cancel a exactly
        if ($urandom_range(0, 39) == 0) begin
            p.mag_b = p.mag_a;
            p.az_b  = pvr_pkg::AZ_W'((int'(p.az_a) % AZ_TURN + AZ_TURN / 2) % AZ_TURN);
        end
        if ($urandom_range(1, 100) <= plant_pct) begin
            sel = $urandom_range(0, 3);
            case (sel)
                0: p.mag_a = nodata_code;
                1: p.az_a  = pvr_pkg::AZ_W'(nodata_code);
                2: p.mag_b = nodata_code;
                default: p.az_b = pvr_pkg::AZ_W'(nodata_code);
            endcase
        end
        return p;
    endfunction

    task automatic queue_random(input int count, input int plant_pct);
        for (int n = 0; n < count; n++)
            pixels_pending.push_back(random_pixel(plant_pct));
    endtask

    task automatic write_reg(input logic [pvr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pvr_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        // mirror only the registers that exist; other indexes are dropped
        if (idx == pvr_pkg::CFG_NODATA_ENABLE) nodata_on = data[0];
        else if (idx == pvr_pkg::CFG_NODATA_VALUE) nodata_code = data;
    endtask

    // Hold until every queued pixel is taken and every result has come back,
    // then let the pipeline empty before touching the registers.
    task automatic drain;
        while (pixels_pending.size() != 0 || resultants_due.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. A beat
    // on the bus is held until it is taken.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic   nv;
        t_pixel np;
        nv = 1'b0;
        np = {pix.magnitude_a, pix.azimuth_a, pix.magnitude_b, pix.azimuth_b};
        if (pix_taken) void'(pixels_pending.pop_front());
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (pix.valid && !pix_taken) begin
            nv = 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
        end else if (pixels_pending.size() != 0) begin
            nv = 1'b1;
            np = pixels_pending[0];
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        pix.valid       <= nv;
        pix.magnitude_a <= np.mag_a;
        pix.azimuth_a   <= np.az_a;
        pix.magnitude_b <= np.mag_b;
        pix.azimuth_b   <= np.az_b;
    end

    // ------------------------------------------------------------------
    // Receiver: ready steps through a repeating pattern of four phases, and
    // once, after enough pixels, drops for a long stretch so the pipeline
    // fills and back-pressures the sender.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic nr;
        nr = 1'b0;
        if (i_rst_n) begin
            rx_cycle++;
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done && pixels_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end else begin
                case ((rx_cycle >> 6) % 4)
                    0: nr = 1'b1;
                    1: nr = ($urandom_range(0, 1) == 1);
                    2: nr = ($urandom_range(0, 4) != 0);
                    default: nr = (rx_cycle % 3 == 0);
                endcase
            end
        end
        res.ready <= nr;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every pixel beat, check every result beat.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_resultant got, want;
        pix_taken = i_rst_n && pix.valid && pix.ready;
        if (pix_taken) begin
            resultants_due.push_back(resolve_pixel(
                {pix.magnitude_a, pix.azimuth_a, pix.magnitude_b, pix.azimuth_b}));
            pixels_taken++;
        end
        if (i_rst_n && res.valid && res.ready) begin
            got = {res.sum_magnitude, res.sum_azimuth, res.missing_pixel};
            results_seen++;
            if (resultants_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat mag=%0d az=%0d missing=%0b",
                         $time, got.mag, got.az, got.missing);
            end else begin
                want = resultants_due.pop_front();
                if (got.missing) missing_seen++;
                if (!got.missing && got.mag == 0) zero_seen++;
                if (got.mag !== want.mag) begin
                    errors++;
                    $display("%0t: sum_magnitude expected %0d actual %0d",
                             $time, want.mag, got.mag);
                end
                if (got.az !== want.az) begin
                    errors++;
                    $display("%0t: sum_azimuth expected %0d actual %0d",
                             $time, want.az, got.az);
                end
                if (got.missing !== want.missing) begin
                    errors++;
                    $display("%0t: missing_pixel expected %0b actual %0b",
                             $time, want.missing, got.missing);
                end
            end
        end
    end

    // Limit: far beyond the slowest legal run.
    initial begin
        #(2 * HALF_CLK * 400000);
        $display("%0t: timeout with %0d pixels queued, %0d results due", $time,
                 pixels_pending.size(), resultants_due.size());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_wdata     = '0;
        pix.valid       = 1'b0;
        pix.magnitude_a = '0;
        pix.azimuth_a   = '0;
        pix.magnitude_b = '0;
        pix.azimuth_b   = '0;
        res.ready       = 1'b0;
        nodata_on       = 1'b0;
        nodata_code     = '0;
        errors          = 0;
        pixels_taken    = 0;
        results_seen    = 0;
        missing_seen    = 0;
        zero_seen       = 0;
        pix_taken       = 1'b0;
        burst_left      = 1;
        gap_left        = 0;
        rx_cycle        = 0;
        hold_left       = 0;
        hold_done       = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Checking off (reset state): extremes, cancellation, wrap.
        pixels_pending.push_back(make_pixel(0, 0, 0, 0));            // null resultant
        pixels_pending.push_back(make_pixel(65535, 0, 65535, 0));    // saturating sum
        pixels_pending.push_back(make_pixel(65535, 5760, 65535, 5760));
        pixels_pending.push_back(make_pixel(65535, 11520, 65535, 17280));
        pixels_pending.push_back(make_pixel(1000, 0, 1000, 11520));  // opposite, cancel
        pixels_pending.push_back(make_pixel(65535, 5760, 65535, 17280));
        pixels_pending.push_back(make_pixel(1, 23039, 0, 0));        // just short of a turn
        pixels_pending.push_back(make_pixel(500, 32767, 500, 23040)); // past one turn
        pixels_pending.push_back(make_pixel(1, 0, 1, 1));
        pixels_pending.push_back(make_pixel(0, 12345, 7, 23039));
        pixels_pending.push_back(make_pixel(65535, 1, 0, 0));
        pixels_pending.push_back(make_pixel(32768, 16384, 21845, 10922));
        queue_random(440, 0);
        drain();

        // Checking on, code zero: plant it in each field in turn.
        write_reg(pvr_pkg::CFG_NODATA_ENABLE, 16'd1);
        write_reg(pvr_pkg::CFG_NODATA_VALUE, 16'd0);
        pixels_pending.push_back(make_pixel(0, 100, 5, 200));
        pixels_pending.push_back(make_pixel(5, 0, 5, 200));
        pixels_pending.push_back(make_pixel(5, 100, 0, 200));
        pixels_pending.push_back(make_pixel(5, 100, 5, 0));
        pixels_pending.push_back(make_pixel(5, 100, 5, 200));
        queue_random(150, 30);
        drain();

        // Code at its top; out-of-range register indexes must be dropped.
        write_reg(pvr_pkg::CFG_NODATA_VALUE, 16'hFFFF);
        write_reg(CFG_UNUSED_LO, 16'h0000);
        write_reg(CFG_UNUSED_HI, 16'h0000);
        pixels_pending.push_back(make_pixel(65535, 0, 3, 3));
        pixels_pending.push_back(make_pixel(3, 3, 65535, 32767));
        queue_random(150, 30);
        drain();

        // A mid-range code that azimuth fields can also hit.
        write_reg(pvr_pkg::CFG_NODATA_VALUE, 16'($urandom_range(1, AZ_TURN - 1)));
        queue_random(150, 30);
        drain();

        // Checking off again with a live code: flag must stay low.
        write_reg(pvr_pkg::CFG_NODATA_ENABLE, 16'd0);
        queue_random(60, 30);
        drain();

        $display("Covered %0d pixels and %0d results across five register settings,",
                 pixels_taken, results_seen);
        $display("with %0d no-data results, %0d zero magnitudes and one long output stall.",
                 missing_seen, zero_seen);
        if (errors == 0 && resultants_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/pvr_pkg.sv
rtl/pvr_in_if.sv
rtl/pvr_out_if.sv
rtl/pvr_front.sv
rtl/pvr_cordic_rot.sv
rtl/pvr_cordic_vec.sv
rtl/polar_vector_resultant.sv
bench/tb_polar_vector_resultant.sv
